// ===== sv/x86alu_pkg.sv =====
// shared types, operation codes and constants for the x86 alu/shift/flags block
// used by x86alu_arith, x86alu_shift, the top level and the port checker
// no dependencies
package x86alu_pkg;

	localparam int XLEN           = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int IN_TDATA_W     = 80;
	localparam int OUT_TDATA_W    = 40;

	typedef logic [XLEN-1:0] word_t;

	typedef enum logic [3:0] {
		FN_ADD  = 4'd0,
		FN_OR   = 4'd1,
		FN_AND  = 4'd2,
		FN_SUB  = 4'd3,
		FN_XOR  = 4'd4,
		FN_CMP  = 4'd5,
		FN_TEST = 4'd6,
		FN_NEG  = 4'd7,
		FN_NOT  = 4'd8,
		FN_ROL  = 4'd9,
		FN_ROR  = 4'd10,
		FN_SHL  = 4'd11,
		FN_SHR  = 4'd12,
		FN_SAR  = 4'd13,
		FN_LOAD = 4'd14
	} func_t;

	// jcc condition pairs, selected by cond_code[3:1]; bit 0 inverts
	typedef enum logic [2:0] {
		CC_O  = 3'd0,
		CC_B  = 3'd1,
		CC_E  = 3'd2,
		CC_BE = 3'd3,
		CC_S  = 3'd4,
		CC_P  = 3'd5,
		CC_L  = 3'd6,
		CC_LE = 3'd7
	} cond_t;

	typedef struct packed {
		logic of;
		logic sf;
		logic zf;
		logic af;
		logic pf;
		logic cf;
	} flags_t;

	// bit positions of the flags in a packed flag word
	localparam int LD_CF = 0;
	localparam int LD_PF = 2;
	localparam int LD_AF = 4;
	localparam int LD_ZF = 6;
	localparam int LD_SF = 7;
	localparam int LD_OF = 11;

	function automatic logic even_parity(input logic [7:0] v);
		even_parity = ~(^v);
	endfunction

endpackage

// ===== sv/x86_alu_shift_flags_top.sv =====
// x86-style alu and shift unit with a six-bit arithmetic flag register
// input register, execute logic (x86alu_arith, x86alu_shift), result register
// depends on x86alu_pkg, x86alu_arith, x86alu_shift
//
// usage
//   s_axis carries one operation request per transfer: func, width select,
//   operand a, operand b and a jcc condition code. m_axis returns the result,
//   the six flags after the operation and whether the condition holds on them.
//   a result passes through the input register and then the result register
//   before it is offered on m_axis; one request is taken every cycle as
//   long as results are taken. the flag register is read
//   and written by the execute logic in the same cycle, so each request sees
//   the flags left by the one before it.
//   when m_axis stalls, the held result waits in the result register and one
//   more request is still taken into the input register; s_axis_tready drops
//   only when both are full.
//   reset clears both valid bits and all six flags.
//   DATA_WIDTH sets the wide operand width (8 to 32); the narrow width is 8.
module x86_alu_shift_flags_top #(
	parameter int DATA_WIDTH = x86alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// func[3:0], width_sel[4], operand_a[36:5], operand_b[68:37],
	// cond_code[72:69], zero fill up to bit 79
	input  logic [x86alu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// result[31:0], carry_flag[32], parity_flag[33], aux_flag[34],
	// zero_flag[35], sign_flag[36], overflow_flag[37], cond_met[38], zero[39]
	output logic [x86alu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import x86alu_pkg::*;

	localparam word_t MaskDw = word_t'({DATA_WIDTH{1'b1}});

	// input register
	logic       valid_s1;
	logic [3:0] func_s1;
	logic       wide_s1;
	word_t      a_s1;
	word_t      b_s1;
	logic [3:0] cc_s1;

	// result register
	logic       valid_s2;
	word_t      res_s2;
	flags_t     flags_s2;
	logic       met_s2;

	flags_t     flags_q;

	logic       advance;
	word_t      mask;
	word_t      a_m;
	word_t      b_m;
	logic [4:0] cnt;
	word_t      arith_res;
	flags_t     arith_flags;
	word_t      shift_res;
	flags_t     shift_flags;
	word_t      res_next;
	flags_t     flags_next;
	logic       met_next;
	logic       cond_raw;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tdata[3:0];
			wide_s1 <= s_axis_tdata[4];
			a_s1    <= s_axis_tdata[36:5];
			b_s1    <= s_axis_tdata[68:37];
			cc_s1   <= s_axis_tdata[72:69];
		end
	end

	always_comb begin
		mask = wide_s1 ? MaskDw : word_t'(8'hFF);
		a_m  = a_s1 & mask;
		b_m  = b_s1 & mask;

		// count masked to five bits, then brought below the width
		cnt = b_s1[4:0];
		if (wide_s1) begin
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, cnt} >= 6'(DATA_WIDTH))
					cnt = cnt - 5'(DATA_WIDTH);
			end
		end else begin
			cnt = {2'b00, b_s1[2:0]};
		end
	end

	x86alu_arith #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_arith (
		.func      (func_s1),
		.wide      (wide_s1),
		.op_a      (a_m),
		.op_b      (b_m),
		.flags_in  (flags_q),
		.result    (arith_res),
		.flags_out (arith_flags)
	);

	x86alu_shift #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_shift (
		.func      (func_s1),
		.wide      (wide_s1),
		.op_a      (a_m),
		.cnt       (cnt),
		.flags_in  (flags_q),
		.result    (shift_res),
		.flags_out (shift_flags)
	);

	always_comb begin
		case (func_s1)
			FN_ROL, FN_ROR, FN_SHL, FN_SHR, FN_SAR: begin
				res_next   = shift_res;
				flags_next = shift_flags;
			end
			FN_LOAD: begin
				res_next      = '0;
				flags_next.cf = a_s1[LD_CF];
				flags_next.pf = a_s1[LD_PF];
				flags_next.af = a_s1[LD_AF];
				flags_next.zf = a_s1[LD_ZF];
				flags_next.sf = a_s1[LD_SF];
				flags_next.of = a_s1[LD_OF];
			end
			default: begin
				res_next   = arith_res;
				flags_next = arith_flags;
			end
		endcase

		case (cond_t'(cc_s1[3:1]))
			CC_O:    cond_raw = flags_next.of;
			CC_B:    cond_raw = flags_next.cf;
			CC_E:    cond_raw = flags_next.zf;
			CC_BE:   cond_raw = flags_next.cf | flags_next.zf;
			CC_S:    cond_raw = flags_next.sf;
			CC_P:    cond_raw = flags_next.pf;
			CC_L:    cond_raw = flags_next.sf ^ flags_next.of;
			CC_LE:   cond_raw = flags_next.zf | (flags_next.sf ^ flags_next.of);
			default: cond_raw = 1'b0;
		endcase
		met_next = cond_raw ^ cc_s1[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance)
				flags_q <= flags_next;
			if (!valid_s2 || m_axis_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res_next;
			flags_s2 <= flags_next;
			met_s2   <= met_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, met_s2, flags_s2.of, flags_s2.sf, flags_s2.zf,
		flags_s2.af, flags_s2.pf, flags_s2.cf, res_s2};

endmodule

// ===== sv/x86alu_arith.sv =====
// add, sub, cmp, neg and logic operations with their flag updates
// operands arrive already masked to the selected width
// depends on x86alu_pkg
module x86alu_arith #(
	parameter int DATA_WIDTH = x86alu_pkg::DATA_WIDTH_DEF
) (
	input  logic [3:0]          func,
	input  logic                wide,
	input  x86alu_pkg::word_t   op_a,
	input  x86alu_pkg::word_t   op_b,
	input  x86alu_pkg::flags_t  flags_in,
	output x86alu_pkg::word_t   result,
	output x86alu_pkg::flags_t  flags_out
);
	import x86alu_pkg::*;

	localparam word_t MaskDw = word_t'({DATA_WIDTH{1'b1}});

	word_t         mask;
	logic [4:0]    top_idx;
	logic [5:0]    wbits;
	word_t         x;
	word_t         y;
	logic [XLEN:0] sum_raw;
	logic [XLEN:0] diff_raw;
	word_t         r_add;
	word_t         r_sub;
	word_t         r_log;
	word_t         add_ov;
	word_t         sub_ov;
	word_t         r_flag;
	logic          upd_res;

	always_comb begin
		mask    = wide ? MaskDw : word_t'(8'hFF);
		top_idx = wide ? 5'(DATA_WIDTH - 1) : 5'd7;
		wbits   = wide ? 6'(DATA_WIDTH) : 6'd8;

		// neg runs as 0 - a
		x = (func == FN_NEG) ? '0 : op_a;
		y = (func == FN_NEG) ? op_a : op_b;

		sum_raw  = {1'b0, x} + {1'b0, y};
		diff_raw = {1'b0, x} - {1'b0, y};
		r_add    = sum_raw[XLEN-1:0] & mask;
		r_sub    = diff_raw[XLEN-1:0] & mask;
		add_ov   = ~(x ^ y) & (x ^ r_add);
		sub_ov   = (x ^ y) & (x ^ r_sub);

		case (func)
			FN_OR:   r_log = op_a | op_b;
			FN_AND:  r_log = op_a & op_b;
			default: r_log = op_a ^ op_b;
		endcase

		flags_out = flags_in;
		result    = '0;
		r_flag    = '0;
		upd_res   = 1'b0;

		case (func)
			FN_ADD: begin
				result       = r_add;
				r_flag       = r_add;
				upd_res      = 1'b1;
				flags_out.cf = sum_raw[wbits];
				flags_out.of = add_ov[top_idx];
				flags_out.af = x[4] ^ y[4] ^ r_add[4];
			end
			FN_SUB, FN_CMP, FN_NEG: begin
				result       = (func == FN_CMP) ? op_a : r_sub;
				r_flag       = r_sub;
				upd_res      = 1'b1;
				flags_out.cf = diff_raw[XLEN];
				flags_out.of = sub_ov[top_idx];
				flags_out.af = x[4] ^ y[4] ^ r_sub[4];
			end
			FN_OR, FN_AND, FN_XOR: begin
				result       = r_log;
				r_flag       = r_log;
				upd_res      = 1'b1;
				flags_out.cf = 1'b0;
				flags_out.of = 1'b0;
				flags_out.af = op_a[4] ^ op_b[4] ^ r_log[4];
			end
			FN_TEST: begin
				// af kept, result passes operand a through
				result       = op_a;
				r_flag       = op_a & op_b;
				upd_res      = 1'b1;
				flags_out.cf = 1'b0;
				flags_out.of = 1'b0;
			end
			FN_NOT: begin
				result = ~op_a & mask;
			end
			default: begin
				result = '0;
			end
		endcase

		if (upd_res) begin
			flags_out.zf = (r_flag == '0);
			flags_out.sf = r_flag[top_idx];
			flags_out.pf = even_parity(r_flag[7:0]);
		end
	end

endmodule

// ===== sv/x86alu_shift.sv =====
// rotate and shift unit with the x86 count-dependent flag rules
// count arrives already reduced below the operand width
// depends on x86alu_pkg
module x86alu_shift #(
	parameter int DATA_WIDTH = x86alu_pkg::DATA_WIDTH_DEF
) (
	input  logic [3:0]          func,
	input  logic                wide,
	input  x86alu_pkg::word_t   op_a,
	input  logic [4:0]          cnt,
	input  x86alu_pkg::flags_t  flags_in,
	output x86alu_pkg::word_t   result,
	output x86alu_pkg::flags_t  flags_out
);
	import x86alu_pkg::*;

	localparam word_t MaskDw = word_t'({DATA_WIDTH{1'b1}});

	word_t      mask;
	logic [4:0] top_idx;
	logic [5:0] wbits;
	logic [5:0] back;
	logic       one;
	word_t      r_rol;
	word_t      r_ror;
	word_t      r_shl;
	word_t      r_shr;
	word_t      r_sar;
	logic       cf_shl;
	logic       cf_shr;
	logic [4:0] top_m1;

	always_comb begin
		mask    = wide ? MaskDw : word_t'(8'hFF);
		top_idx = wide ? 5'(DATA_WIDTH - 1) : 5'd7;
		top_m1  = top_idx - 5'd1;
		wbits   = wide ? 6'(DATA_WIDTH) : 6'd8;
		back    = wbits - {1'b0, cnt};
		one     = (cnt == 5'd1);

		r_rol  = ((op_a << cnt) | (op_a >> back)) & mask;
		r_ror  = ((op_a >> cnt) | (op_a << back)) & mask;
		r_shl  = (op_a << cnt) & mask;
		r_shr  = op_a >> cnt;
		r_sar  = r_shr | (op_a[top_idx] ? (mask & ~(mask >> cnt)) : '0);
		// last bit shifted out; count is at least one where these are used
		cf_shl = op_a[back[4:0]];
		cf_shr = op_a[cnt - 5'd1];

		flags_out = flags_in;
		result    = op_a;

		if (cnt != '0) begin
			case (func)
				FN_ROL: begin
					result       = r_rol;
					flags_out.cf = r_rol[0];
					if (one)
						flags_out.of = r_rol[top_idx] ^ r_rol[0];
				end
				FN_ROR: begin
					result       = r_ror;
					flags_out.cf = r_ror[top_idx];
					if (one)
						flags_out.of = r_ror[top_idx] ^ r_ror[top_m1];
				end
				FN_SHL: begin
					result       = r_shl;
					flags_out.cf = cf_shl;
					flags_out.of = one & (r_shl[top_idx] ^ cf_shl);
				end
				FN_SHR: begin
					result       = r_shr;
					flags_out.cf = cf_shr;
					flags_out.of = one & op_a[top_idx];
				end
				FN_SAR: begin
					result       = r_sar;
					flags_out.cf = cf_shr;
					flags_out.of = 1'b0;
				end
				default: begin
					result = op_a;
				end
			endcase

			if (func == FN_SHL || func == FN_SHR || func == FN_SAR) begin
				flags_out.zf = (result == '0);
				flags_out.sf = result[top_idx];
				flags_out.pf = even_parity(result[7:0]);
			end
		end
	end

endmodule

// ===== sv/x86alu_port_chk.sv =====
// port-level checker for x86_alu_shift_flags_top, attached by bind
// watches handshakes, latency and the flag load path
// depends on x86alu_pkg
module x86alu_port_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic [x86alu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [x86alu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import x86alu_pkg::*;

	logic s_acc;
	logic ld_req;

	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign ld_req = s_acc && (s_axis_tdata[3:0] == FN_LOAD);

	// an empty result register never blocks requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("s_axis_tready low with empty output");

	// a result that is not taken stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a request accepted while the output stays open gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result missing two cycles after request");

	// flag load returns zero and the packed flag bits
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_req && m_axis_tready ##1 m_axis_tready |=>
		m_axis_tdata[31:0] == '0 &&
		m_axis_tdata[32] == $past(s_axis_tdata[5 + LD_CF], 2) &&
		m_axis_tdata[33] == $past(s_axis_tdata[5 + LD_PF], 2) &&
		m_axis_tdata[34] == $past(s_axis_tdata[5 + LD_AF], 2) &&
		m_axis_tdata[35] == $past(s_axis_tdata[5 + LD_ZF], 2) &&
		m_axis_tdata[36] == $past(s_axis_tdata[5 + LD_SF], 2) &&
		m_axis_tdata[37] == $past(s_axis_tdata[5 + LD_OF], 2))
		else $error("flag load result wrong");

endmodule

bind x86_alu_shift_flags_top x86alu_port_chk u_port_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_x86_alu_shift_flags_top.sv =====
`timescale 1ns / 100ps
// testbench for x86_alu_shift_flags_top: directed and random alu/shift requests
// with random idling on both streams, checked against a flag-tracking predictor
// depends on x86alu_pkg and the x86_alu_shift_flags_top rtl
module tb_x86_alu_shift_flags_top;
	import x86alu_pkg::*;

	localparam int        WIDE_W         = DATA_WIDTH_DEF;
	localparam int        WATCHDOG_LIMIT = 2000;
	localparam int        RANDOM_OPS     = 1750;
	localparam int        HOLD_CYCLES    = 64;
	localparam logic [3:0] FN_NOP        = 4'd15;

	typedef struct {
		logic [3:0] fn;
		logic       wide;
		word_t      opa;
		word_t      opb;
		logic [3:0] cc;
	} alu_req_t;

	typedef struct {
		word_t  result;
		flags_t flags;
		logic   cond;
	} alu_outcome_t;

	class alu_outcome_board;
		// flags start cleared, as after reset
		flags_t       flags = '0;
		alu_outcome_t pending_outcomes[$];
		int           mismatches;
		int           requests;
		int           results;
		int           cond_true;
		int           per_func[16];
		string        flag_names[6] = '{"CF", "PF", "AF", "ZF", "SF", "OF"};

		function int pending();
			return pending_outcomes.size();
		endfunction

		function void set_result_flags(bit [63:0] r, int unsigned w);
			bit [63:0] sh;
			sh = r >> (w - 1);
			flags.zf = (r == 0);
			flags.sf = sh[0];
			flags.pf = ~(^r[7:0]);
		endfunction

		function alu_outcome_t compute_outcome(alu_req_t rq);
			int unsigned  w;
			int unsigned  cnt;
			bit [63:0]    mask, top, a, b, x, y, r, raw, xyr, tmp;
			bit           cf, of, t;
			alu_outcome_t e;
			w    = rq.wide ? WIDE_W : 8;
			mask = (64'd1 << w) - 1;
			top  = 64'd1 << (w - 1);
			a    = rq.opa & mask;
			b    = rq.opb & mask;
			cnt  = {27'd0, rq.opb[4:0]};
			if (cnt >= w)
				cnt = cnt % w;
			r = 0;
			case (rq.fn)
				FN_ADD, FN_SUB, FN_CMP, FN_NEG: begin
					x = a;
					y = b;
					if (rq.fn == FN_NEG) begin
						x = 0;
						y = a;
					end
					if (rq.fn == FN_ADD) begin
						raw      = x + y;
						r        = raw & mask;
						flags.cf = raw > mask;
						flags.of = ((~(x ^ y)) & (x ^ r) & top) != 0;
					end else begin
						r        = (x - y) & mask;
						flags.cf = x < y;
						flags.of = ((x ^ y) & (x ^ r) & top) != 0;
					end
					xyr      = x ^ y ^ r;
					flags.af = xyr[4];
					set_result_flags(r, w);
					if (rq.fn == FN_CMP)
						r = a;
				end
				FN_OR, FN_AND, FN_XOR: begin
					r = (rq.fn == FN_OR) ? (a | b) : (rq.fn == FN_AND) ? (a & b) : (a ^ b);
					flags.cf = 1'b0;
					flags.of = 1'b0;
					xyr      = a ^ b ^ r;
					flags.af = xyr[4];
					set_result_flags(r, w);
				end
				FN_TEST: begin
					set_result_flags(a & b, w);
					flags.cf = 1'b0;
					flags.of = 1'b0;
					r = a;
				end
				FN_NOT: r = (~a) & mask;
				FN_ROL, FN_ROR, FN_SHL, FN_SHR, FN_SAR: begin
					if (cnt == 0) begin
						r = a;
					end else if (rq.fn == FN_ROL) begin
						r        = ((a << cnt) | (a >> (w - cnt))) & mask;
						tmp      = r >> (w - 1);
						flags.cf = r[0];
						if (cnt == 1)
							flags.of = tmp[0] ^ r[0];
					end else if (rq.fn == FN_ROR) begin
						r        = ((a >> cnt) | (a << (w - cnt))) & mask;
						tmp      = r >> (w - 2);
						flags.cf = tmp[1];
						if (cnt == 1)
							flags.of = tmp[1] ^ tmp[0];
					end else begin
						of = 1'b0;
						if (rq.fn == FN_SHL) begin
							tmp = a >> (w - cnt);
							cf  = tmp[0];
							r   = (a << cnt) & mask;
							tmp = r >> (w - 1);
							if (cnt == 1)
								of = tmp[0] ^ cf;
						end else begin
							tmp = a >> (cnt - 1);
							cf  = tmp[0];
							r   = a >> cnt;
							if (rq.fn == FN_SHR) begin
								if (cnt == 1)
									of = (a & top) != 0;
							end else if ((a & top) != 0) begin
								// arithmetic shift fills with the sign
								r = r | (mask & ~(mask >> cnt));
							end
						end
						set_result_flags(r, w);
						flags.cf = cf;
						flags.of = of;
					end
				end
				FN_LOAD: begin
					flags.cf = rq.opa[LD_CF];
					flags.pf = rq.opa[LD_PF];
					flags.af = rq.opa[LD_AF];
					flags.zf = rq.opa[LD_ZF];
					flags.sf = rq.opa[LD_SF];
					flags.of = rq.opa[LD_OF];
					r = 0;
				end
				default: r = 0;
			endcase
			case (cond_t'(rq.cc[3:1]))
				CC_O:    t = flags.of;
				CC_B:    t = flags.cf;
				CC_E:    t = flags.zf;
				CC_BE:   t = flags.cf | flags.zf;
				CC_S:    t = flags.sf;
				CC_P:    t = flags.pf;
				CC_L:    t = flags.sf ^ flags.of;
				default: t = flags.zf | (flags.sf ^ flags.of);
			endcase
			e.result = r[31:0];
			e.flags  = flags;
			e.cond   = t ^ rq.cc[0];
			return e;
		endfunction

		function void note_request(alu_req_t rq);
			pending_outcomes.push_back(compute_outcome(rq));
			requests++;
			per_func[rq.fn]++;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("[%0t] mismatch on result %0d: %s", $time, results, msg);
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] d);
			alu_outcome_t e;
			results++;
			if (pending_outcomes.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			e = pending_outcomes.pop_front();
			if (d[31:0] !== e.result)
				report($sformatf("result %h, predicted %h", d[31:0], e.result));
			for (int k = 0; k < 6; k++)
				if (d[32+k] !== e.flags[k])
					report($sformatf("%s %b, predicted %b", flag_names[k], d[32+k],
						e.flags[k]));
			if (d[38] !== e.cond)
				report($sformatf("cond_met %b, predicted %b", d[38], e.cond));
			if (e.cond)
				cond_true++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	alu_outcome_board board;
	int results_seen = 0;
	int stall_cycles = 0;

	x86_alu_shift_flags_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic alu_req_t make_req(logic [3:0] fn, logic wide, word_t opa, word_t opb,
		logic [3:0] cc);
		alu_req_t rq;
		rq.fn   = fn;
		rq.wide = wide;
		rq.opa  = opa;
		rq.opb  = opb;
		rq.cc   = cc;
		return rq;
	endfunction

	function automatic alu_req_t unpack_req(logic [IN_TDATA_W-1:0] d);
		return make_req(d[3:0], d[4], d[36:5], d[68:37], d[72:69]);
	endfunction

	// operands biased toward the sign and carry boundaries of both widths
	function automatic word_t pick_operand();
		word_t v;
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			2:       v = 32'h8000_0000;
			3:       v = 32'h7FFF_FFFF;
			4:       v = $urandom_range(0, 255);
			5:       v = ($urandom() & 32'hFFFF_FF00) | ($urandom_range(0, 1) ? 32'h80 : 32'h7F);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic alu_req_t random_req();
		alu_req_t rq;
		rq = make_req(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), pick_operand(),
			pick_operand(), 4'($urandom_range(0, 15)));
		// count of one is the only case in which a shift can set OF
		if (rq.fn inside {FN_ROL, FN_ROR, FN_SHL, FN_SHR, FN_SAR} && $urandom_range(0, 3) == 0)
			rq.opb[4:0] = 5'd1;
		return rq;
	endfunction

	task automatic send_op(input alu_req_t rq, input bit may_idle);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, rq.cc, rq.opb, rq.opa, rq.wide, rq.fn};
		do @(posedge clk); while (!s_axis_tready);
		if (may_idle && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// requests are noted and results checked in one process, values sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(unpack_req(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_result(m_axis_tdata);
				results_seen <= results_seen + 1;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, board.pending());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// result side: random backpressure, one long hold-off, one window always ready
	initial begin
		bit held;
		held = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (results_seen >= 700 && results_seen < 1000) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 20);
			end
		end
	end

	initial begin
		int funcs_hit;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flag load with every bit set, then the arithmetic edges
		send_op(make_req(FN_LOAD, 1'b1, 32'hFFFF_FFFF, 32'h0, {CC_O, 1'b0}), 1'b1);
		send_op(make_req(FN_ADD, 1'b0, 32'hFFFF_FF7F, 32'h0000_0001, {CC_O, 1'b0}), 1'b1);
		send_op(make_req(FN_ADD, 1'b0, 32'h0000_00FF, 32'hFFFF_FF01, {CC_E, 1'b0}), 1'b1);
		send_op(make_req(FN_ADD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {CC_B, 1'b0}), 1'b1);
		send_op(make_req(FN_SUB, 1'b1, 32'h8000_0000, 32'h0000_0001, {CC_L, 1'b0}), 1'b1);
		send_op(make_req(FN_SUB, 1'b0, 32'h0000_0000, 32'h0000_0001, {CC_BE, 1'b1}), 1'b1);
		send_op(make_req(FN_CMP, 1'b1, 32'h0000_0005, 32'h0000_0005, {CC_E, 1'b0}), 1'b1);
		send_op(make_req(FN_NEG, 1'b0, 32'hFFFF_FF00, 32'h0, {CC_B, 1'b1}), 1'b1);
		send_op(make_req(FN_NEG, 1'b1, 32'h8000_0000, 32'h0, {CC_O, 1'b0}), 1'b1);
		send_op(make_req(FN_OR, 1'b1, 32'h0, 32'h0, {CC_E, 1'b1}), 1'b1);
		send_op(make_req(FN_AND, 1'b0, 32'hFFFF_FF0F, 32'h1234_56F0, {CC_LE, 1'b0}), 1'b1);
		send_op(make_req(FN_XOR, 1'b1, 32'hFFFF_FFFF, 32'h0, {CC_S, 1'b0}), 1'b1);
		send_op(make_req(FN_TEST, 1'b0, 32'h0000_0080, 32'hFFFF_FFFF, {CC_S, 1'b1}), 1'b1);
		send_op(make_req(FN_NOT, 1'b1, 32'h0F0F_0F0F, 32'h0, {CC_P, 1'b0}), 1'b1);
		send_op(make_req(FN_ROL, 1'b1, 32'h8000_0000, 32'h0000_0001, {CC_O, 1'b0}), 1'b1);
		send_op(make_req(FN_ROR, 1'b0, 32'h0000_0001, 32'h0000_0001, {CC_O, 1'b1}), 1'b1);
		// count of zero after the five-bit mask
		send_op(make_req(FN_SHL, 1'b0, 32'h0000_00FF, 32'h0000_0020, {CC_B, 1'b0}), 1'b1);
		// count above the narrow width wraps to one
		send_op(make_req(FN_SHL, 1'b0, 32'h0000_0080, 32'h0000_0009, {CC_O, 1'b0}), 1'b1);
		send_op(make_req(FN_SHR, 1'b1, 32'hFFFF_FFFF, 32'h0000_001F, {CC_B, 1'b0}), 1'b1);
		send_op(make_req(FN_SAR, 1'b0, 32'h0000_0080, 32'h0000_0007, {CC_L, 1'b1}), 1'b1);
		send_op(make_req(FN_SAR, 1'b1, 32'h8000_0001, 32'h0000_0001, {CC_LE, 1'b1}), 1'b1);
		// count sixteen on a byte reduces to zero
		send_op(make_req(FN_ROL, 1'b0, 32'h0000_00A5, 32'h0000_0010, {CC_P, 1'b1}), 1'b1);
		send_op(make_req(FN_NOP, 1'b1, 32'hDEAD_BEEF, 32'h1234_5678, {CC_BE, 1'b0}), 1'b1);
		send_op(make_req(FN_LOAD, 1'b0, 32'h0000_0000, 32'h0, {CC_LE, 1'b1}), 1'b1);
		send_op(make_req(FN_ROR, 1'b1, 32'h0000_0001, 32'h0000_001F, {CC_S, 1'b0}), 1'b1);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			send_op(random_req(), !(i >= 600 && i < 900));
			if (i == 1200) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
			end
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);

		funcs_hit = 0;
		foreach (board.per_func[f])
			if (board.per_func[f] != 0)
				funcs_hit++;
		$display("covered %0d requests over %0d function codes at both widths, %0d results",
			board.requests, funcs_hit, board.results);
		$display("condition held on %0d results, %0d mismatches", board.cond_true,
			board.mismatches);
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/x86alu_pkg.sv
sv/x86alu_arith.sv
sv/x86alu_shift.sv
sv/x86_alu_shift_flags_top.sv
sv/x86alu_port_chk.sv
dv/tb_x86_alu_shift_flags_top.sv
